// ===== design/sct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape collision tester package
// Function codes, controller commands and datapath status shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sct_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RECT  = 2'd1,
    FUNC_RC    = 2'd2,
    FUNC_CC    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    AX_NONE,
    AX_EDGE,
    AX_VEC
  } axis_op_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AX_X,
    MUL_AY_Y,
    MUL_DX2,
    MUL_DY2,
    MUL_AXX,
    MUL_AYY,
    MUL_RS2,
    MUL_R2,
    MUL_D_LL,
    MUL_D_LH,
    MUL_D_HH,
    MUL_T_LL,
    MUL_T_LH,
    MUL_T_HL,
    MUL_T_HH
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_1,
    SH_2
  } acc_sh_t;

  typedef enum logic [3:0] {
    SV_NONE,
    SV_SPAN_A_INIT,
    SV_SPAN_A,
    SV_SPAN_B_INIT,
    SV_SPAN_B,
    SV_AC,
    SV_GAP,
    SV_TREG,
    SV_RR,
    SV_AA,
    SV_BEST_INIT,
    SV_BEST
  } save_op_t;

  typedef struct packed {
    logic     wr_en;
    logic     rd_en;
    logic [2:0] rd_addr;
    logic     q_load;
    logic     c_load;
    axis_op_t axis_op;
    mul_op_t  mul_op;
    acc_op_t  acc_op;
    acc_sh_t  acc_sh;
    save_op_t save_op;
    logic [1:0] vidx;
  } cmd_t;

  typedef struct packed {
    logic       span_sep;
    logic       gap_pos;
    logic       acc_gt;
    logic       acc_lt;
    logic [1:0] best;
  } status_t;

endpackage

// ===== design/sct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape collision tester RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sct_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape collision tester datapath
// Point store, shared multiplier, accumulator and projection registers.
// ----------------------------------------------------------------------------
module sct_datapath #(
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sct_pkg::cmd_t        cmd,
  output sct_pkg::status_t     status,
  input  logic [2:0]           slot,
  input  logic signed [15:0]   point_x,
  input  logic signed [15:0]   point_y,
  input  logic [14:0]          radius
);

  import sct_pkg::*;

  localparam int C = COORD_BITS;
  localparam int H = (C + 1 > 16) ? C + 1 : 16;
  localparam int D = 2 * C + 3;
  localparam int W = 4 * H + 2;

  logic [2*C-1:0]      ram_q;
  logic [2*C-1:0]      ram_d;
  logic [7:0]          valid;
  logic                rd_valid;
  logic [14:0]         ra;
  logic [14:0]         rb;
  logic [15:0]         rs;

  logic signed [C-1:0] rx;
  logic signed [C-1:0] ry;
  logic signed [C-1:0] qx;
  logic signed [C-1:0] qy;
  logic signed [C-1:0] cx;
  logic signed [C-1:0] cy;
  logic signed [C:0]   ax;
  logic signed [C:0]   ay;
  logic signed [C:0]   dx;
  logic signed [C:0]   dy;

  logic signed [H:0]     op_a;
  logic signed [H:0]     op_b;
  logic signed [2*H+1:0] prod;
  logic signed [W-1:0]   pext;
  logic signed [W-1:0]   term;
  logic signed [W-1:0]   acc;
  logic signed [W-1:0]   treg;

  logic signed [D-1:0] dot;
  logic signed [D-1:0] mn_a;
  logic signed [D-1:0] mx_a;
  logic signed [D-1:0] mn_b;
  logic signed [D-1:0] mx_b;
  logic signed [D-1:0] ac;
  logic signed [D-1:0] gap_val;
  logic [2*H-1:0]      gap;
  logic                gap_pos;
  logic [2*H-1:0]      rr;
  logic [2*H-1:0]      aa;
  logic [2*H-1:0]      best_d;
  logic [1:0]          best;

  assign ram_d = {C'($unsigned(point_x)), C'($unsigned(point_y))};

  sct_ram #(
    .WIDTH (2 * C),
    .DEPTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (slot),
    .wdata (ram_d),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (ram_q)
  );

  assign rx = rd_valid ? ram_q[2*C-1:C] : '0;
  assign ry = rd_valid ? ram_q[C-1:0] : '0;
  assign dx = (C+1)'(rx) - (C+1)'(cx);
  assign dy = (C+1)'(ry) - (C+1)'(cy);
  assign rs = 16'(ra) + 16'(rb);
  assign dot = acc[D-1:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_op)
      MUL_AX_X: begin op_a = (H+1)'(ax); op_b = (H+1)'(rx); end
      MUL_AY_Y: begin op_a = (H+1)'(ay); op_b = (H+1)'(ry); end
      MUL_DX2:  begin op_a = (H+1)'(dx); op_b = (H+1)'(dx); end
      MUL_DY2:  begin op_a = (H+1)'(dy); op_b = (H+1)'(dy); end
      MUL_AXX:  begin op_a = (H+1)'(ax); op_b = (H+1)'(ax); end
      MUL_AYY:  begin op_a = (H+1)'(ay); op_b = (H+1)'(ay); end
      MUL_RS2:  begin op_a = (H+1)'(rs); op_b = (H+1)'(rs); end
      MUL_R2:   begin op_a = (H+1)'(rb); op_b = (H+1)'(rb); end
      MUL_D_LL: begin op_a = {1'b0, gap[H-1:0]};   op_b = {1'b0, gap[H-1:0]};   end
      MUL_D_LH: begin op_a = {1'b0, gap[H-1:0]};   op_b = {1'b0, gap[2*H-1:H]}; end
      MUL_D_HH: begin op_a = {1'b0, gap[2*H-1:H]}; op_b = {1'b0, gap[2*H-1:H]}; end
      MUL_T_LL: begin op_a = {1'b0, rr[H-1:0]};    op_b = {1'b0, aa[H-1:0]};    end
      MUL_T_LH: begin op_a = {1'b0, rr[H-1:0]};    op_b = {1'b0, aa[2*H-1:H]};  end
      MUL_T_HL: begin op_a = {1'b0, rr[2*H-1:H]};  op_b = {1'b0, aa[H-1:0]};    end
      MUL_T_HH: begin op_a = {1'b0, rr[2*H-1:H]};  op_b = {1'b0, aa[2*H-1:H]};  end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  assign pext = W'(prod);

  always_comb begin
    case (cmd.acc_sh)
      SH_1:    term = pext <<< H;
      SH_2:    term = pext <<< (2 * H);
      default: term = pext;
    endcase
  end

  always_comb begin
    if (ac > mx_a) begin
      gap_val = ac - mx_a;
    end else if (mn_a > ac) begin
      gap_val = mn_a - ac;
    end else begin
      gap_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      ra       <= '0;
      rb       <= '0;
    end else begin
      if (cmd.wr_en) begin
        valid[slot] <= 1'b1;
        if (slot[1:0] == 2'b00) begin
          if (slot[2]) begin
            rb <= radius;
          end else begin
            ra <= radius;
          end
        end
      end
      if (cmd.rd_en) begin
        rd_valid <= valid[cmd.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    case (cmd.acc_op)
      ACC_LOAD: acc <= term;
      ACC_ADD:  acc <= acc + term;
      default:  acc <= acc;
    endcase
    if (cmd.q_load) begin
      qx <= rx;
      qy <= ry;
    end
    if (cmd.c_load) begin
      cx <= rx;
      cy <= ry;
    end
    case (cmd.axis_op)
      AX_EDGE: begin
        ax <= (C+1)'(qy) - (C+1)'(ry);
        ay <= (C+1)'(rx) - (C+1)'(qx);
      end
      AX_VEC: begin
        ax <= dx;
        ay <= dy;
      end
      default: begin
        ax <= ax;
        ay <= ay;
      end
    endcase
    case (cmd.save_op)
      SV_SPAN_A_INIT: begin mn_a <= dot; mx_a <= dot; end
      SV_SPAN_A: begin
        if (dot < mn_a) mn_a <= dot;
        if (dot > mx_a) mx_a <= dot;
      end
      SV_SPAN_B_INIT: begin mn_b <= dot; mx_b <= dot; end
      SV_SPAN_B: begin
        if (dot < mn_b) mn_b <= dot;
        if (dot > mx_b) mx_b <= dot;
      end
      SV_AC: ac <= dot;
      SV_GAP: begin
        gap     <= (2*H)'($unsigned(gap_val));
        gap_pos <= (gap_val != '0);
      end
      SV_TREG: treg <= acc;
      SV_RR:   rr <= acc[2*H-1:0];
      SV_AA:   aa <= acc[2*H-1:0];
      SV_BEST_INIT: begin
        best_d <= acc[2*H-1:0];
        best   <= cmd.vidx;
      end
      SV_BEST: begin
        if (acc < $signed({{(W-2*H){1'b0}}, best_d})) begin
          best_d <= acc[2*H-1:0];
          best   <= cmd.vidx;
        end
      end
      default: begin end
    endcase
  end

  assign status.span_sep = (mx_a < mn_b) || (mx_b < mn_a);
  assign status.gap_pos  = gap_pos;
  assign status.acc_gt   = acc > treg;
  assign status.acc_lt   = acc < treg;
  assign status.best     = best;

endmodule

// ===== design/sct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape collision tester controller
// Sequences axis set-up, projections, gap, nearest-corner and squared-extent checks.
// ----------------------------------------------------------------------------
module sct_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       func,
  output logic             busy,
  output logic             done,
  output logic             collision,
  output sct_pkg::cmd_t    cmd,
  input  sct_pkg::status_t status
);

  import sct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RC_INIT,
    S_CC,
    S_EDGE0,
    S_EDGE1,
    S_EDGE2,
    S_PROJ,
    S_RR_CHK,
    S_GAP,
    S_GAP_CHK,
    S_AA,
    S_T,
    S_D2,
    S_NEAR,
    S_VEC0,
    S_VEC1
  } state_t;

  state_t     state;
  func_t      func_q;
  logic [2:0] step;
  logic [2:0] vcnt;
  logic [1:0] axis;
  logic [2:0] edge0;
  logic [2:0] edge1;
  logic [2:0] vlast;

  assign busy  = (state != S_IDLE);
  assign edge0 = {axis[1], 1'b0, axis[0]};
  assign edge1 = {axis[1], axis[0], ~axis[0]};
  assign vlast = (func_q == FUNC_RECT) ? 3'd7 : 3'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      func_q    <= FUNC_WRITE;
      step      <= '0;
      vcnt      <= '0;
      axis      <= '0;
      done      <= 1'b0;
      collision <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          step <= '0;
          vcnt <= '0;
          axis <= '0;
          if (start) begin
            func_q <= func_t'(func);
            unique case (func_t'(func))
              FUNC_RECT: state <= S_EDGE0;
              FUNC_RC:   state <= S_RC_INIT;
              FUNC_CC:   state <= S_CC;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_RC_INIT: begin
          if (step == 3'd2) begin
            step  <= '0;
            state <= S_EDGE0;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_CC: begin
          if (step == 3'd5) begin
            done      <= 1'b1;
            collision <= status.acc_lt;
            state     <= S_IDLE;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_EDGE0: state <= S_EDGE1;
        S_EDGE1: state <= S_EDGE2;
        S_EDGE2: begin
          vcnt  <= '0;
          step  <= '0;
          state <= S_PROJ;
        end
        S_VEC0: state <= S_VEC1;
        S_VEC1: begin
          vcnt  <= '0;
          step  <= '0;
          state <= S_PROJ;
        end
        S_PROJ: begin
          if (step == 3'd4) begin
            step <= '0;
            if (vcnt == vlast) begin
              state <= (func_q == FUNC_RECT) ? S_RR_CHK : S_GAP;
            end else begin
              vcnt <= vcnt + 3'd1;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        S_RR_CHK: begin
          if (status.span_sep || axis == 2'd3) begin
            done      <= 1'b1;
            collision <= ~status.span_sep;
            state     <= S_IDLE;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_EDGE0;
          end
        end
        S_GAP: state <= S_GAP_CHK;
        S_GAP_CHK, S_D2: begin
          if (state == S_D2 && step != 3'd5) begin
            step <= step + 3'd1;
          end else if (state == S_GAP_CHK && status.gap_pos) begin
            step  <= '0;
            state <= S_AA;
          end else if (state == S_D2 && status.acc_gt) begin
            done      <= 1'b1;
            collision <= 1'b0;
            state     <= S_IDLE;
          end else begin
            step <= '0;
            vcnt <= '0;
            if (axis == 2'd0) begin
              axis  <= 2'd1;
              state <= S_EDGE0;
            end else if (axis == 2'd1) begin
              axis  <= 2'd2;
              state <= S_NEAR;
            end else begin
              done      <= 1'b1;
              collision <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        S_AA: begin
          if (step == 3'd3) begin
            step  <= '0;
            state <= S_T;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_T: begin
          if (step == 3'd5) begin
            step  <= '0;
            state <= S_D2;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_NEAR: begin
          if (step == 3'd4) begin
            step <= '0;
            if (vcnt == 3'd3) begin
              state <= S_VEC0;
            end else begin
              vcnt <= vcnt + 3'd1;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '{wr_en: 1'b0, rd_en: 1'b0, rd_addr: 3'd0, q_load: 1'b0, c_load: 1'b0,
            axis_op: AX_NONE, mul_op: MUL_NONE, acc_op: ACC_HOLD, acc_sh: SH_0,
            save_op: SV_NONE, vidx: 2'd0};
    unique case (state)
      S_IDLE: cmd.wr_en = start && (func == FUNC_WRITE);
      S_RC_INIT: begin
        case (step)
          3'd0: begin cmd.rd_en = 1'b1; cmd.rd_addr = 3'd4; cmd.mul_op = MUL_R2; end
          3'd1: begin cmd.c_load = 1'b1; cmd.acc_op = ACC_LOAD; end
          default: cmd.save_op = SV_RR;
        endcase
      end
      S_CC: begin
        case (step)
          3'd0: begin cmd.rd_en = 1'b1; cmd.rd_addr = 3'd4; cmd.mul_op = MUL_RS2; end
          3'd1: begin
            cmd.c_load  = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = 3'd0;
            cmd.acc_op  = ACC_LOAD;
          end
          3'd2: begin cmd.save_op = SV_TREG; cmd.mul_op = MUL_DX2; end
          3'd3: begin cmd.mul_op = MUL_DY2; cmd.acc_op = ACC_LOAD; end
          3'd4: cmd.acc_op = ACC_ADD;
          default: begin end
        endcase
      end
      S_EDGE0: begin cmd.rd_en = 1'b1; cmd.rd_addr = edge0; end
      S_EDGE1: begin cmd.q_load = 1'b1; cmd.rd_en = 1'b1; cmd.rd_addr = edge1; end
      S_EDGE2: cmd.axis_op = AX_EDGE;
      S_VEC0:  begin cmd.rd_en = 1'b1; cmd.rd_addr = {1'b0, status.best}; end
      S_VEC1:  cmd.axis_op = AX_VEC;
      S_PROJ: begin
        case (step)
          3'd0: begin cmd.rd_en = 1'b1; cmd.rd_addr = vcnt; end
          3'd1: cmd.mul_op = MUL_AX_X;
          3'd2: begin cmd.mul_op = MUL_AY_Y; cmd.acc_op = ACC_LOAD; end
          3'd3: cmd.acc_op = ACC_ADD;
          default: begin
            if (vcnt == 3'd0) cmd.save_op = SV_SPAN_A_INIT;
            else if (vcnt < 3'd4) cmd.save_op = SV_SPAN_A;
            else if (func_q != FUNC_RECT) cmd.save_op = SV_AC;
            else if (vcnt == 3'd4) cmd.save_op = SV_SPAN_B_INIT;
            else cmd.save_op = SV_SPAN_B;
          end
        endcase
      end
      S_GAP: cmd.save_op = SV_GAP;
      S_AA: begin
        case (step)
          3'd0: cmd.mul_op = MUL_AXX;
          3'd1: begin cmd.mul_op = MUL_AYY; cmd.acc_op = ACC_LOAD; end
          3'd2: cmd.acc_op = ACC_ADD;
          default: cmd.save_op = SV_AA;
        endcase
      end
      S_T: begin
        case (step)
          3'd0: cmd.mul_op = MUL_T_LL;
          3'd1: begin cmd.mul_op = MUL_T_LH; cmd.acc_op = ACC_LOAD; end
          3'd2: begin cmd.mul_op = MUL_T_HL; cmd.acc_op = ACC_ADD; cmd.acc_sh = SH_1; end
          3'd3: begin cmd.mul_op = MUL_T_HH; cmd.acc_op = ACC_ADD; cmd.acc_sh = SH_1; end
          3'd4: begin cmd.acc_op = ACC_ADD; cmd.acc_sh = SH_2; end
          default: cmd.save_op = SV_TREG;
        endcase
      end
      S_D2: begin
        case (step)
          3'd0: cmd.mul_op = MUL_D_LL;
          3'd1: begin cmd.mul_op = MUL_D_LH; cmd.acc_op = ACC_LOAD; end
          3'd2: begin cmd.mul_op = MUL_D_LH; cmd.acc_op = ACC_ADD; cmd.acc_sh = SH_1; end
          3'd3: begin cmd.mul_op = MUL_D_HH; cmd.acc_op = ACC_ADD; cmd.acc_sh = SH_1; end
          3'd4: begin cmd.acc_op = ACC_ADD; cmd.acc_sh = SH_2; end
          default: begin end
        endcase
      end
      S_NEAR: begin
        cmd.vidx = vcnt[1:0];
        case (step)
          3'd0: begin cmd.rd_en = 1'b1; cmd.rd_addr = vcnt; end
          3'd1: cmd.mul_op = MUL_DX2;
          3'd2: begin cmd.mul_op = MUL_DY2; cmd.acc_op = ACC_LOAD; end
          3'd3: cmd.acc_op = ACC_ADD;
          default: cmd.save_op = (vcnt == 3'd0) ? SV_BEST_INIT : SV_BEST;
        endcase
      end
      default: begin end
    endcase
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a test in progress");
  a_test_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func != FUNC_WRITE) |=> busy)
    else $error("test transfer did not start the sequencer");
  a_read_when_busy: assert property (@(posedge clk) disable iff (rst) cmd.rd_en |-> busy)
    else $error("store read while idle");
  a_write_when_idle: assert property (@(posedge clk) disable iff (rst) cmd.wr_en |-> !busy)
    else $error("store write while busy");
`endif

endmodule

// ===== design/shape_collision_tester.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape collision tester
// Rectangle and circle collision tests on an eight-slot point store.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transfer happens at a clock edge with start high and busy low.
//   func 0 writes point_x/point_y into slot (radius too for slots 0 and 4);
//   it finishes at that edge, busy stays low and no result follows.
//   func 1 (rect-rect), 2 (rect-circle), 3 (circle-circle) raise busy and
//   give one result: done high for exactly one cycle with collision.
//   Sequence from the accepting edge to the done cycle:
//     circle-circle: one squared-distance check against the summed radii;
//     rect-rect: projections of both rectangles on each edge axis in turn,
//     with early exit on a separating axis;
//     rect-circle: set-up, both edge axes of the rectangle, a nearest-corner
//     search, then the corner axis; each axis with a gap gets a squared check.
//   Test length is set by one shared 18x18 multiplier (wider at larger
//   COORD_BITS) and the single read port of the point store: each corner
//   takes a read and two products; wide squared extents take partial products.
//   One item at a time: busy drops in the cycle done is shown.
//   Reset clears the store to zero points and radii and returns to idle.
//   The receiver cannot stall; done is a strobe to be taken when shown.
// ----------------------------------------------------------------------------
module shape_collision_tester #(
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [2:0]         slot,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [14:0]        radius,
  output logic               done,
  output logic               collision
);

  import sct_pkg::*;

  cmd_t    cmd;
  status_t status;

  sct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .busy      (busy),
    .done      (done),
    .collision (collision),
    .cmd       (cmd),
    .status    (status)
  );

  sct_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .slot    (slot),
    .point_x (point_x),
    .point_y (point_y),
    .radius  (radius)
  );

endmodule
